// ----- design/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, constants and byte helpers for the content type sniffer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned HEAD_LEN       = 12;
  localparam int unsigned CTRL_DIVISOR   = 50;
  localparam int unsigned MULT_EXTRA     = 6;

  localparam logic [7:0] LEAD_MIN = 8'hc2;
  localparam logic [7:0] LEAD_MAX = 8'hf4;

  localparam logic [63:0] SIG_PNG   = 64'h89_50_4e_47_0d_0a_1a_0a;
  localparam logic [23:0] SIG_JPEG  = 24'hff_d8_ff;
  localparam logic [47:0] SIG_GIF7  = 48'h47_49_46_38_37_61;
  localparam logic [47:0] SIG_GIF9  = 48'h47_49_46_38_39_61;
  localparam logic [39:0] SIG_PDF   = 40'h25_50_44_46_2d;
  localparam logic [31:0] SIG_ZIP1  = 32'h50_4b_03_04;
  localparam logic [31:0] SIG_ZIP2  = 32'h50_4b_05_06;
  localparam logic [31:0] SIG_ZIP3  = 32'h50_4b_07_08;
  localparam logic [15:0] SIG_GZIP  = 16'h1f_8b;
  localparam logic [15:0] SIG_BMP   = 16'h42_4d;
  localparam logic [31:0] SIG_ELF   = 32'h7f_45_4c_46;
  localparam logic [31:0] SIG_RIFF  = 32'h52_49_46_46;
  localparam logic [31:0] SIG_WEBP  = 32'h57_45_42_50;
  localparam logic [15:0] BOM_U16LE = 16'hff_fe;
  localparam logic [15:0] BOM_U16BE = 16'hfe_ff;
  localparam logic [23:0] BOM_U8    = 24'hef_bb_bf;

  typedef enum logic [3:0] {
    CLS_OCTET = 4'd0,
    CLS_PNG   = 4'd1,
    CLS_JPEG  = 4'd2,
    CLS_GIF   = 4'd3,
    CLS_PDF   = 4'd4,
    CLS_ZIP   = 4'd5,
    CLS_GZIP  = 4'd6,
    CLS_BMP   = 4'd7,
    CLS_ELF   = 4'd8,
    CLS_WEBP  = 4'd9,
    CLS_TEXT  = 4'd10
  } content_class_t;

  typedef logic [HEAD_LEN-1:0][7:0] head_t;

  typedef struct packed {
    logic           hit;
    content_class_t cls;
  } sig_res_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] pend;
  } utf8_st_t;

  function automatic logic is_stray(input logic [7:0] b);
    is_stray = (b < 8'h20) && (b != 8'h08) && (b != 8'h09) && (b != 8'h0a)
               && (b != 8'h0c) && (b != 8'h0d);
  endfunction

  function automatic utf8_st_t utf8_step(input utf8_st_t st, input logic [7:0] b);
    utf8_st_t r;
    r = st;
    if (st.ok) begin
      if (st.pend != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          r.ok = 1'b0;
        end else begin
          r.pend = st.pend - 2'd1;
        end
      end else if (!b[7]) begin
        r.pend = 2'd0;
      end else if (b[7:5] == 3'b110) begin
        if (b < LEAD_MIN) begin
          r.ok = 1'b0;
        end else begin
          r.pend = 2'd1;
        end
      end else if (b[7:4] == 4'b1110) begin
        r.pend = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        if (b > LEAD_MAX) begin
          r.ok = 1'b0;
        end else begin
          r.pend = 2'd3;
        end
      end else begin
        r.ok = 1'b0;
      end
    end
    utf8_step = r;
  endfunction

endpackage

// ----- design/sct_if.sv -----
// ----------------------------------------------------------------------------
// sct_in_if / sct_out_if
// Valid/ready stream channels for buffer bytes and class results.
// ----------------------------------------------------------------------------
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_buffer;

  modport source (output valid, output data_byte, output last_byte,
                  output empty_buffer, input ready);
  modport sink (input valid, input data_byte, input last_byte,
                input empty_buffer, output ready);
endinterface

interface sct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] content_class;

  modport source (output valid, output content_class, input ready);
  modport sink (input valid, input content_class, output ready);
endinterface

// ----- design/sct_sig_match.sv -----
// ----------------------------------------------------------------------------
// sct_sig_match
// Priority match of the buffer head against file signatures and BOMs.
// ----------------------------------------------------------------------------
module sct_sig_match (
  input  sct_pkg::head_t   head,
  output sct_pkg::sig_res_t res
);

  // unseen head bytes read as zero and no signature byte is zero
  always_comb begin
    res.hit = 1'b1;
    res.cls = sct_pkg::CLS_OCTET;
    if ({head[0], head[1], head[2], head[3], head[4], head[5], head[6], head[7]}
        == sct_pkg::SIG_PNG) begin
      res.cls = sct_pkg::CLS_PNG;
    end else if ({head[0], head[1], head[2]} == sct_pkg::SIG_JPEG) begin
      res.cls = sct_pkg::CLS_JPEG;
    end else if ({head[0], head[1], head[2], head[3], head[4], head[5]}
                 == sct_pkg::SIG_GIF7 ||
                 {head[0], head[1], head[2], head[3], head[4], head[5]}
                 == sct_pkg::SIG_GIF9) begin
      res.cls = sct_pkg::CLS_GIF;
    end else if ({head[0], head[1], head[2], head[3], head[4]} == sct_pkg::SIG_PDF) begin
      res.cls = sct_pkg::CLS_PDF;
    end else if ({head[0], head[1], head[2], head[3]} == sct_pkg::SIG_ZIP1 ||
                 {head[0], head[1], head[2], head[3]} == sct_pkg::SIG_ZIP2 ||
                 {head[0], head[1], head[2], head[3]} == sct_pkg::SIG_ZIP3) begin
      res.cls = sct_pkg::CLS_ZIP;
    end else if ({head[0], head[1]} == sct_pkg::SIG_GZIP) begin
      res.cls = sct_pkg::CLS_GZIP;
    end else if ({head[0], head[1]} == sct_pkg::SIG_BMP) begin
      res.cls = sct_pkg::CLS_BMP;
    end else if ({head[0], head[1], head[2], head[3]} == sct_pkg::SIG_ELF) begin
      res.cls = sct_pkg::CLS_ELF;
    end else if ({head[0], head[1], head[2], head[3]} == sct_pkg::SIG_RIFF &&
                 {head[8], head[9], head[10], head[11]} == sct_pkg::SIG_WEBP) begin
      res.cls = sct_pkg::CLS_WEBP;
    end else if ({head[0], head[1]} == sct_pkg::BOM_U16LE ||
                 {head[0], head[1]} == sct_pkg::BOM_U16BE ||
                 {head[0], head[1], head[2]} == sct_pkg::BOM_U8) begin
      res.cls = sct_pkg::CLS_TEXT;
    end else begin
      res.hit = 1'b0;
    end
  end

endmodule

// ----- design/stream_content_type_sniffer.sv -----
// ----------------------------------------------------------------------------
// stream_content_type_sniffer
// Classifies a byte stream buffer by magic number, BOM or loose UTF-8 text.
// ----------------------------------------------------------------------------
// One word carries one byte of a buffer; the word with last_byte set, or an
// empty_buffer word, ends the buffer and yields one content_class word. The
// block takes one word every cycle with no gaps between buffers, unless a
// final word waits behind an untaken result. Each word is registered on
// entry and then folded into the running buffer state; a buffer's class is
// registered in the output register as its final word is folded in, and
// stays there until taken while input keeps flowing until a second result
// would have to queue behind it. The text threshold max(1, count/50) is
// checked as stray <= 1 || stray*50 <= count, stray*50 as a running register.
module stream_content_type_sniffer #(
  parameter int unsigned COUNT_BITS = sct_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  sct_in_if.sink         in_chan,
  sct_out_if.source      out_chan
);

  localparam int unsigned S50W = COUNT_BITS + sct_pkg::MULT_EXTRA;

  logic                 v1_r;
  logic [7:0]           byte1_r;
  logic                 last1_r;
  logic                 empty1_r;

  logic [COUNT_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [COUNT_BITS-1:0] stray_r, stray_nxt;
  logic [S50W-1:0]       stray50_r, stray50_nxt;
  sct_pkg::head_t        head_r, head_nxt;
  sct_pkg::utf8_st_t     utf8_r, utf8_nxt;
  logic                  zero_r, zero_nxt;

  logic                  out_valid_r;
  sct_pkg::content_class_t cls_r, cls_nxt;

  logic                  take;
  logic                  ends;
  logic                  adv;
  logic                  inc_stray;
  sct_pkg::sig_res_t     sig;

  assign take = v1_r && !empty1_r;
  assign ends = v1_r && (empty1_r || last1_r);
  assign adv  = v1_r && (!ends || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !v1_r || adv;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.content_class = cls_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_chan.ready) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte1_r  <= in_chan.data_byte;
      last1_r  <= in_chan.last_byte;
      empty1_r <= in_chan.empty_buffer;
    end
  end

  // running buffer state after the registered word
  always_comb begin
    inc_stray      = take && sct_pkg::is_stray(byte1_r) && (stray_r != '1);
    bytes_seen_nxt = bytes_seen_r;
    stray_nxt      = stray_r;
    stray50_nxt    = stray50_r;
    head_nxt       = head_r;
    utf8_nxt       = utf8_r;
    zero_nxt       = zero_r;
    if (take) begin
      for (int i = 0; i < sct_pkg::HEAD_LEN; i++) begin
        if (bytes_seen_r == COUNT_BITS'(i)) begin
          head_nxt[i] = byte1_r;
        end
      end
      if (bytes_seen_r != '1) begin
        bytes_seen_nxt = bytes_seen_r + COUNT_BITS'(1);
      end
      if (byte1_r == 8'h00) begin
        zero_nxt = 1'b1;
      end
      utf8_nxt = sct_pkg::utf8_step(utf8_r, byte1_r);
    end
    if (inc_stray) begin
      stray_nxt   = stray_r + COUNT_BITS'(1);
      stray50_nxt = stray50_r + S50W'(sct_pkg::CTRL_DIVISOR);
    end
  end

  sct_sig_match u_sig (
    .head (head_nxt),
    .res  (sig)
  );

  always_comb begin
    if (bytes_seen_nxt == '0) begin
      cls_nxt = sct_pkg::CLS_OCTET;
    end else if (sig.hit) begin
      cls_nxt = sig.cls;
    end else if (!utf8_nxt.ok || utf8_nxt.pend != 2'd0 || zero_nxt) begin
      cls_nxt = sct_pkg::CLS_OCTET;
    end else if (stray_nxt <= COUNT_BITS'(1) ||
                 stray50_nxt <= {{sct_pkg::MULT_EXTRA{1'b0}}, bytes_seen_nxt}) begin
      cls_nxt = sct_pkg::CLS_TEXT;
    end else begin
      cls_nxt = sct_pkg::CLS_OCTET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      stray_r      <= '0;
      stray50_r    <= '0;
      head_r       <= '0;
      utf8_r       <= '{ok: 1'b1, pend: 2'd0};
      zero_r       <= 1'b0;
    end else if (adv) begin
      if (ends) begin
        bytes_seen_r <= '0;
        stray_r      <= '0;
        stray50_r    <= '0;
        head_r       <= '0;
        utf8_r       <= '{ok: 1'b1, pend: 2'd0};
        zero_r       <= 1'b0;
      end else begin
        bytes_seen_r <= bytes_seen_nxt;
        stray_r      <= stray_nxt;
        stray50_r    <= stray50_nxt;
        head_r       <= head_nxt;
        utf8_r       <= utf8_nxt;
        zero_r       <= zero_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && ends) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ends) begin
      cls_r <= cls_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ends) |=> (bytes_seen_r == '0 && stray_r == '0 && head_r == '0))
    else $error("buffer state not cleared after result");

  a_stray_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    stray_r <= bytes_seen_r)
    else $error("stray control count exceeds byte count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(cls_r)))
    else $error("pending result lost or overwritten");

  a_stray50_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (stray_r == '0) |-> (stray50_r == '0))
    else $error("scaled stray count out of step");
`endif

endmodule
